### hw/rtl/zip_central_directory_parser_core_macros.svh
// Assertion macros shared by the parser RTL.
`ifndef ZIP_CENTRAL_DIRECTORY_PARSER_CORE_MACROS_SVH
`define ZIP_CENTRAL_DIRECTORY_PARSER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ZCDP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define ZCDP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/zcdp_pkg.sv
// Package: types and constants of the ZIP central directory parser.
package zcdp_pkg;

  localparam int unsigned NAME_MAX_DEF = 256;
  localparam int unsigned HDR_LEN      = 46;
  localparam logic [31:0] CD_SIG       = 32'h0201_4b50;
  localparam logic [5:0]  HDR_LAST     = 6'(HDR_LEN - 1);

  typedef enum logic [2:0] {
    PH_HEADER   = 3'd0,
    PH_NAME     = 3'd1,
    PH_SKIP     = 3'd2,
    PH_FINISHED = 3'd3,
    PH_ERR_SIG  = 3'd4,
    PH_ERR_END  = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    K_NAME   = 2'd0,
    K_RECORD = 2'd1,
    K_ERROR  = 2'd2,
    K_EMPTY  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    E_NONE = 2'd0,
    E_SIG  = 2'd1,
    E_END  = 2'd2
  } err_t;

  // Decoded fields of the captured entry header.
  typedef struct packed {
    logic [31:0] sig;
    logic [15:0] method;
    logic [31:0] crc;
    logic [31:0] packed_sz;
    logic [31:0] plain_sz;
    logic [31:0] offset;
    logic [15:0] fn_len;
    logic [16:0] skip;
  } hdr_t;

  // One result item.
  typedef struct packed {
    kind_t       kind;
    logic [15:0] entry_index;
    logic [7:0]  name_char;
    logic [11:0] name_position;
    logic [15:0] method;
    logic [31:0] crc_value;
    logic [31:0] packed_size;
    logic [31:0] plain_size;
    logic [31:0] header_offset;
    logic [15:0] name_length;
    logic        final_entry;
    err_t        error_code;
  } res_t;

endpackage

### hw/rtl/zcdp_ifs.sv
// Channel interfaces: byte input, result output, configuration write.
interface zcdp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_data;
  modport source (output valid, data_byte, end_of_data, input ready);
  modport sink (input valid, data_byte, end_of_data, output ready);
endinterface

interface zcdp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] entry_index;
  logic [7:0]  name_char;
  logic [11:0] name_position;
  logic [15:0] method;
  logic [31:0] crc_value;
  logic [31:0] packed_size;
  logic [31:0] plain_size;
  logic [31:0] header_offset;
  logic [15:0] name_length;
  logic        final_entry;
  logic [1:0]  error_code;
  modport source (output valid, kind, entry_index, name_char, name_position, method,
                  crc_value, packed_size, plain_size, header_offset, name_length,
                  final_entry, error_code, input ready);
  modport sink (input valid, kind, entry_index, name_char, name_position, method,
                crc_value, packed_size, plain_size, header_offset, name_length,
                final_entry, error_code, output ready);
endinterface

interface zcdp_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

### hw/rtl/zcdp_hdr.sv
// Entry header byte store with little-endian field decode.
module zcdp_hdr
  import zcdp_pkg::*;
(
  input  logic       clk,
  input  logic       wr_en,
  input  logic [5:0] wr_idx,
  input  logic [7:0] wr_byte,
  input  logic       live_last,
  output hdr_t       hdr
);

  logic [7:0] hdr_r [HDR_LEN];
  logic [7:0] off_hi;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      hdr_r[wr_idx] <= wr_byte;
    end
  end

  // last header byte is not stored yet on the cycle it arrives
  assign off_hi = live_last ? wr_byte : hdr_r[45];

  always_comb begin
    hdr.sig       = {hdr_r[3], hdr_r[2], hdr_r[1], hdr_r[0]};
    hdr.method    = {hdr_r[11], hdr_r[10]};
    hdr.crc       = {hdr_r[19], hdr_r[18], hdr_r[17], hdr_r[16]};
    hdr.packed_sz = {hdr_r[23], hdr_r[22], hdr_r[21], hdr_r[20]};
    hdr.plain_sz  = {hdr_r[27], hdr_r[26], hdr_r[25], hdr_r[24]};
    hdr.offset    = {off_hi, hdr_r[44], hdr_r[43], hdr_r[42]};
    hdr.fn_len    = {hdr_r[29], hdr_r[28]};
    hdr.skip      = {1'b0, hdr_r[31], hdr_r[30]} + {1'b0, hdr_r[33], hdr_r[32]};
  end

endmodule

### hw/rtl/zip_central_directory_parser_core.sv
// Parses a ZIP central directory one byte per item into name bytes, entry records
// and errors. One input item is taken per clock: the byte is decoded against the
// parser state in one combinational step and the result (if any) is written to a
// single output register, so sustained throughput is one byte per cycle while the
// result side keeps up; each result shows in the cycle after its byte is taken.
// Name bytes from position NAME_MAX-1 on are dropped; extra and comment bytes
// produce no result. Errors are sticky and repeat on every later item; after the
// last expected record or the empty-directory report, later bytes are swallowed.
`include "zip_central_directory_parser_core_macros.svh"

module zip_central_directory_parser_core
  import zcdp_pkg::*;
#(
  parameter int unsigned NAME_MAX = NAME_MAX_DEF
) (
  input  logic clk,
  input  logic rst_n,
  zcdp_in_if.sink    in_ch,
  zcdp_out_if.source out_ch,
  zcdp_cfg_if.sink   cfg_ch
);

  localparam logic [15:0] KEEP_LIM = 16'(NAME_MAX - 1);

  logic [15:0] expected_r;
  phase_t      phase_r, phase_nxt;
  logic [5:0]  hc_r, hc_nxt;
  logic [15:0] nc_r, nc_nxt;
  logic [16:0] skip_r, skip_nxt, skip_dec;
  logic [15:0] done_r, done_nxt, done_inc;
  logic        out_valid_r;
  res_t        out_r, res;
  logic        has_res;
  logic        do_rec, rec_keep;
  logic        in_acc;
  logic        eod;
  logic [7:0]  b;
  logic        err_ph;
  hdr_t        hdr;

  assign eod          = in_ch.end_of_data;
  assign b            = in_ch.data_byte;
  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign err_ph       = (phase_r == PH_ERR_END) || (phase_r == PH_ERR_SIG);

  zcdp_hdr u_hdr (
    .clk       (clk),
    .wr_en     (in_acc && (phase_r == PH_HEADER)),
    .wr_idx    (hc_r),
    .wr_byte   (b),
    .live_last (phase_r == PH_HEADER),
    .hdr       (hdr)
  );

  assign done_inc = done_r + 16'd1;
  assign skip_dec = (skip_r != 17'd0) ? skip_r - 17'd1 : skip_r;

  always_comb begin
    phase_nxt       = phase_r;
    hc_nxt          = hc_r;
    nc_nxt          = nc_r;
    skip_nxt        = skip_r;
    done_nxt        = done_r;
    res             = '0;
    res.entry_index = done_r;
    has_res         = 1'b0;
    do_rec          = 1'b0;
    rec_keep        = 1'b0;
    unique case (phase_r)
      PH_HEADER: begin
        if (hc_r == 6'd0 && done_r >= expected_r) begin
          phase_nxt = PH_FINISHED;
          if (done_r == 16'd0) begin
            has_res  = 1'b1;
            res.kind = K_EMPTY;
          end
        end else if (hc_r != HDR_LAST) begin
          hc_nxt = hc_r + 6'd1;
          if (eod) begin
            phase_nxt      = PH_ERR_END;
            has_res        = 1'b1;
            res.kind       = K_ERROR;
            res.error_code = E_END;
          end
        end else begin
          hc_nxt = 6'd0;
          if (hdr.sig != CD_SIG) begin
            phase_nxt      = PH_ERR_SIG;
            has_res        = 1'b1;
            res.kind       = K_ERROR;
            res.error_code = E_SIG;
          end else if (hdr.fn_len == 16'd0) begin
            do_rec = 1'b1;
          end else if (eod) begin
            phase_nxt      = PH_ERR_END;
            has_res        = 1'b1;
            res.kind       = K_ERROR;
            res.error_code = E_END;
          end else begin
            nc_nxt    = 16'd0;
            phase_nxt = PH_NAME;
          end
        end
      end
      PH_NAME: begin
        if ({1'b0, nc_r} + 17'd1 >= {1'b0, hdr.fn_len}) begin
          do_rec   = 1'b1;
          rec_keep = nc_r < KEEP_LIM;
        end else if (eod) begin
          phase_nxt      = PH_ERR_END;
          has_res        = 1'b1;
          res.kind       = K_ERROR;
          res.error_code = E_END;
        end else begin
          if (nc_r < KEEP_LIM) begin
            has_res           = 1'b1;
            res.kind          = K_NAME;
            res.name_char     = b;
            res.name_position = nc_r[11:0];
          end
          nc_nxt = nc_r + 16'd1;
        end
      end
      PH_SKIP: begin
        if (eod) begin
          phase_nxt      = PH_ERR_END;
          has_res        = 1'b1;
          res.kind       = K_ERROR;
          res.error_code = E_END;
        end else begin
          skip_nxt = skip_dec;
          if (skip_dec == 17'd0) begin
            hc_nxt    = 6'd0;
            phase_nxt = PH_HEADER;
          end
        end
      end
      PH_ERR_SIG: begin
        has_res        = 1'b1;
        res.kind       = K_ERROR;
        res.error_code = E_SIG;
      end
      PH_ERR_END: begin
        has_res        = 1'b1;
        res.kind       = K_ERROR;
        res.error_code = E_END;
      end
      default: begin
      end
    endcase

    if (do_rec) begin
      has_res           = 1'b1;
      res.kind          = K_RECORD;
      res.name_char     = rec_keep ? b : 8'd0;
      res.name_position = rec_keep ? nc_r[11:0] : 12'd0;
      res.method        = hdr.method;
      res.crc_value     = hdr.crc;
      res.packed_size   = hdr.packed_sz;
      res.plain_size    = hdr.plain_sz;
      res.header_offset = hdr.offset;
      res.name_length   = hdr.fn_len;
      done_nxt          = done_inc;
      hc_nxt            = 6'd0;
      if (done_inc >= expected_r) begin
        res.final_entry = 1'b1;
        phase_nxt       = PH_FINISHED;
      end else if (eod) begin
        phase_nxt = PH_ERR_END;
      end else begin
        skip_nxt  = hdr.skip;
        phase_nxt = (hdr.skip != 17'd0) ? PH_SKIP : PH_HEADER;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_r <= 16'd0;
      phase_r    <= PH_HEADER;
      hc_r       <= 6'd0;
      nc_r       <= 16'd0;
      skip_r     <= 17'd0;
      done_r     <= 16'd0;
    end else begin
      if (cfg_ch.valid) begin
        expected_r <= cfg_ch.data;
      end
      if (in_acc) begin
        phase_r <= phase_nxt;
        hc_r    <= hc_nxt;
        nc_r    <= nc_nxt;
        skip_r  <= skip_nxt;
        done_r  <= done_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= has_res;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && has_res) begin
      out_r <= res;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.kind          = out_r.kind;
  assign out_ch.entry_index   = out_r.entry_index;
  assign out_ch.name_char     = out_r.name_char;
  assign out_ch.name_position = out_r.name_position;
  assign out_ch.method        = out_r.method;
  assign out_ch.crc_value     = out_r.crc_value;
  assign out_ch.packed_size   = out_r.packed_size;
  assign out_ch.plain_size    = out_r.plain_size;
  assign out_ch.header_offset = out_r.header_offset;
  assign out_ch.name_length   = out_r.name_length;
  assign out_ch.final_entry   = out_r.final_entry;
  assign out_ch.error_code    = out_r.error_code;

  `ZCDP_ASSERT_NOW(a_hc_range, 1'b1, hc_r <= HDR_LAST, "header count out of range")
  `ZCDP_ASSERT_NEXT(a_err_sticky, err_ph, phase_r == $past(phase_r), "error phase left")
  `ZCDP_ASSERT_NEXT(a_err_emit, in_acc && err_ph, out_valid_r && out_r.kind == K_ERROR, "no error")
  `ZCDP_ASSERT_NEXT(a_fin_quiet, in_acc && phase_r == PH_FINISHED, !out_valid_r, "late item")
  `ZCDP_ASSERT_NOW(a_empty_zero, out_valid_r && out_r.kind == K_EMPTY, done_r == 16'd0, "bad empty")

endmodule
